FILE: design/hkrb_pkg.sv
// shared types and constants for the keyboard report builder
package hkrb_pkg;

  localparam int KEY_SLOTS  = 6;
  localparam int REPORT_LEN = 8;
  localparam int SLOT_BASE  = 2;
  localparam int CNT_W      = $clog2(REPORT_LEN);

  typedef enum logic [1:0] {
    OP_PRESS       = 2'd0,
    OP_RELEASE     = 2'd1,
    OP_RELEASE_ALL = 2'd2,
    OP_READ        = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_READY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT,
    S_ERR
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic emit;
    logic err;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fail;
    logic last;
  } stat_t;

endpackage

FILE: design/hid_keyboard_report_builder_top.sv
// boot keyboard report builder: 6 slots plus modifier byte, one report byte per cycle
// after the accepting edge the controller passes through S_EXEC (slot update), then gives the first result
// a word that yields a report gives the update plus 8 bytes, an error word gives one error result;
//   the next word is taken during the final result cycle
// results leave one per cycle on strobe, the receiver cannot stall
// rst (synchronous) clears the modifier byte, all key slots and the controller
module hid_keyboard_report_builder_top
  import hkrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] op,
  input  logic [7:0] modifier_bits,
  input  logic [7:0] key_usage,
  input  logic       host_ready,
  output logic       strobe,
  output logic [7:0] report_byte,
  output logic [2:0] byte_index,
  output logic [1:0] status,
  output logic       last_byte
);

  cmd_t  cmd;
  stat_t stat;

  hkrb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .cmd    (cmd),
    .stat   (stat)
  );

  hkrb_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .op            (op),
    .modifier_bits (modifier_bits),
    .key_usage     (key_usage),
    .host_ready    (host_ready),
    .report_byte   (report_byte),
    .byte_index    (byte_index),
    .status        (status),
    .last_byte     (last_byte)
  );

endmodule

FILE: design/hkrb_dp.sv
// datapath: report state, slot search and byte output
module hkrb_dp
  import hkrb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic [1:0]       op,
  input  logic [7:0]       modifier_bits,
  input  logic [7:0]       key_usage,
  input  logic             host_ready,
  output logic [7:0]       report_byte,
  output logic [2:0]       byte_index,
  output logic [1:0]       status,
  output logic             last_byte
);

  op_t                  op_q;
  logic [7:0]           mods_q;
  logic [7:0]           usage_q;
  logic                 ready_q;
  logic [7:0]           modifier_reg;
  logic [7:0]           key_slots [KEY_SLOTS];
  logic [CNT_W-1:0]     cnt;
  status_t              err_code;

  logic [KEY_SLOTS-1:0] match;
  logic [KEY_SLOTS-1:0] empty;
  logic [KEY_SLOTS-1:0] match_first;
  logic [KEY_SLOTS-1:0] empty_first;
  logic                 match_any;
  logic                 empty_any;
  logic                 no_space;
  logic                 not_ready;
  logic [7:0]           report [REPORT_LEN];
  logic                 dup;

  // input word capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= op_t'(op);
      mods_q  <= modifier_bits;
      usage_q <= key_usage;
      ready_q <= host_ready;
    end
  end

  // slot search: a held usage wins over the first empty slot
  always_comb begin
    match_any   = 1'b0;
    empty_any   = 1'b0;
    match_first = '0;
    empty_first = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      match[i] = (key_slots[i] == usage_q);
      empty[i] = (key_slots[i] == 8'd0);
      if (match[i] && !match_any) begin
        match_first[i] = 1'b1;
      end
      if (empty[i] && !empty_any) begin
        empty_first[i] = 1'b1;
      end
      match_any = match_any | match[i];
      empty_any = empty_any | empty[i];
    end
  end

  assign no_space  = (op_q == OP_PRESS) && (usage_q != 8'd0) && !match_any && !empty_any;
  assign not_ready = (op_q != OP_READ) && !ready_q;
  assign stat.fail = no_space || not_ready;
  assign stat.last = (cnt == CNT_W'(REPORT_LEN - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      modifier_reg <= 8'd0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        key_slots[i] <= 8'd0;
      end
    end else if (cmd.exec) begin
      unique case (op_q)
        OP_PRESS: begin
          modifier_reg <= modifier_reg | mods_q;
          if (usage_q != 8'd0) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
              if (match_any ? match_first[i] : empty_first[i]) begin
                key_slots[i] <= usage_q;
              end
            end
          end
        end
        OP_RELEASE: begin
          modifier_reg <= modifier_reg & ~mods_q;
          if (usage_q != 8'd0) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
              if (match[i]) begin
                key_slots[i] <= 8'd0;
              end
            end
          end
        end
        OP_RELEASE_ALL: begin
          modifier_reg <= 8'd0;
          for (int i = 0; i < KEY_SLOTS; i++) begin
            key_slots[i] <= 8'd0;
          end
        end
        OP_READ: begin
        end
        default: begin
        end
      endcase
    end
  end

  // no space is checked before host readiness
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      err_code <= no_space ? ST_NO_SPACE : ST_NOT_READY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.exec) begin
      cnt <= '0;
    end else if (cmd.emit) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  // report layout: modifiers, reserved zero, then the slots
  always_comb begin
    for (int k = 0; k < REPORT_LEN; k++) begin
      report[k] = 8'd0;
      if (k == 0) begin
        report[k] = modifier_reg;
      end else if (k >= SLOT_BASE && (k - SLOT_BASE) < KEY_SLOTS) begin
        report[k] = key_slots[k - SLOT_BASE];
      end
    end
  end

  always_comb begin
    if (cmd.err) begin
      report_byte = 8'd0;
      byte_index  = 3'd0;
      status      = err_code;
      last_byte   = 1'b1;
    end else begin
      report_byte = report[cnt];
      byte_index  = 3'(cnt);
      status      = ST_OK;
      last_byte   = stat.last;
    end
  end

  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      for (int j = i + 1; j < KEY_SLOTS; j++) begin
        if (key_slots[i] != 8'd0 && key_slots[i] == key_slots[j]) begin
          dup = 1'b1;
        end
      end
    end
  end

  a_no_dup_usage: assert property (@(posedge clk) disable iff (rst) !dup)
    else $error("usage held in two slots");

  a_cnt_steps: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && !stat.last |=> cnt == $past(cnt) + CNT_W'(1))
    else $error("byte counter skipped");

  a_read_keeps_state: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && op_q == OP_READ |=> modifier_reg == $past(modifier_reg))
    else $error("read changed modifiers");

endmodule

FILE: design/hkrb_ctrl.sv
// controller: sequences update, report bytes and error word
module hkrb_ctrl
  import hkrb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  output logic  strobe,
  output cmd_t  cmd,
  input  stat_t stat
);

  state_t state;
  state_t state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = stat.fail ? S_ERR : S_EMIT;
      end
      S_EMIT: begin
        if (stat.last) state_next = start ? S_EXEC : S_IDLE;
      end
      S_ERR: begin
        state_next = start ? S_EXEC : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // a new word is taken during the final result cycle
  always_comb begin
    busy     = 1'b1;
    strobe   = 1'b0;
    cmd      = '0;
    unique case (state)
      S_IDLE: busy = 1'b0;
      S_EXEC: cmd.exec = 1'b1;
      S_EMIT: begin
        strobe   = 1'b1;
        cmd.emit = 1'b1;
        busy     = !stat.last;
      end
      S_ERR: begin
        strobe  = 1'b1;
        cmd.err = 1'b1;
        busy    = 1'b0;
      end
      default: busy = 1'b1;
    endcase
    cmd.load = start && !busy;
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_EXEC)
    else $error("accepted word not executed");

  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |=> strobe)
    else $error("update not followed by a result");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    state == S_ERR |=> state == S_IDLE || state == S_EXEC)
    else $error("error word repeated");

endmodule
